### sv/bpbs_pkg.sv
package bpbs_pkg;

   localparam int VALUE_BITS_DEF  = 32;
   localparam int FIFO_DEPTH_DEF  = 8;
   localparam int STEPS_PER_STAGE = 8;
   localparam int MAX_OUT_BYTES   = 6;
   localparam int OUT_NIBBLES     = 2 * MAX_OUT_BYTES;

   localparam logic [3:0] SIGN_NIBBLE = 4'hB;
   localparam logic [3:0] TERM_NIBBLE = 4'hF;
   localparam logic [3:0] PAD_NIBBLE  = 4'h0;
   localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
   localparam logic [3:0] BCD_ADJ     = 4'd3;

   typedef logic [3:0] nibble_type;

   // one encoded value, bytes left-aligned, first byte in the top bits
   typedef struct packed {
      logic [8*MAX_OUT_BYTES-1:0] bytes;
      logic [2:0]                 total;
      logic [2:0]                 emit;
   } enc_item_type;

   // decimal digits needed for a bits-wide unsigned number (log10(2) ~ 0.30103)
   function automatic int bcd_digits(input int bits);
      return (bits * 30103) / 100000 + 1;
   endfunction

endpackage

### sv/bpbs_dabble_stage.sv
module bpbs_dabble_stage #(
   parameter int VALUE_BITS = 32,
   parameter int DIGITS     = 10,
   parameter int STEPS      = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic                  in_neg,
   input  logic [4*DIGITS-1:0]   in_bcd,
   input  logic [VALUE_BITS-1:0] in_bin,
   output logic                  out_valid,
   output logic                  out_neg,
   output logic [4*DIGITS-1:0]   out_bcd,
   output logic [VALUE_BITS-1:0] out_bin
);
   import bpbs_pkg::*;

   logic                  valid_ff;
   logic                  neg_ff;
   logic [4*DIGITS-1:0]   bcd_ff, bcd_in;
   logic [VALUE_BITS-1:0] bin_ff, bin_in;

   // shift-and-add-3, msb of the binary word first
   always_comb begin
      bcd_in = in_bcd;
      bin_in = in_bin;
      for (int t = 0; t < STEPS; t++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (bcd_in[4*d +: 4] >= BCD_ADJ_MIN) begin
               bcd_in[4*d +: 4] = bcd_in[4*d +: 4] + BCD_ADJ;
            end
         end
         bcd_in = {bcd_in[4*DIGITS-2:0], bin_in[VALUE_BITS-1]};
         bin_in = {bin_in[VALUE_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= in_neg;
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
   end

   assign out_valid = valid_ff;
   assign out_neg   = neg_ff;
   assign out_bcd   = bcd_ff;
   assign out_bin   = bin_ff;

endmodule

### sv/bpbs_pack.sv
module bpbs_pack #(
   parameter int DIGITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic                   in_neg,
   input  logic [4*DIGITS-1:0]    in_bcd,
   output logic                   out_valid,
   output bpbs_pkg::enc_item_type out_item
);
   import bpbs_pkg::*;

   localparam int NDW = $clog2(DIGITS + 1);
   localparam int EW  = 4 * (DIGITS + OUT_NIBBLES);

   logic                va_ff;
   logic                neg_a_ff;
   logic [4*DIGITS-1:0] dig_a_ff;
   logic [NDW-1:0]      nd_a_ff, nd_a_in;

   logic                vb_ff;
   enc_item_type        item_ff, item_in;

   logic [NDW-1:0]      shift;
   logic [4*DIGITS-1:0] aligned;
   logic [EW-1:0]       ext;
   logic [NDW:0]        nn;
   logic [NDW-1:0]      tot;

   // count of significant digits, zero still has one
   always_comb begin
      nd_a_in = NDW'(1);
      for (int i = 0; i < DIGITS; i++) begin
         if (in_bcd[4*i +: 4] != '0) begin
            nd_a_in = NDW'(i + 1);
         end
      end
   end

   always_comb begin
      int p;
      nibble_type nib;
      shift   = NDW'(DIGITS) - nd_a_ff;
      aligned = dig_a_ff << {shift, 2'b00};
      ext     = {aligned, {(4*OUT_NIBBLES){1'b0}}};
      item_in.bytes = '0;
      for (int k = 0; k < OUT_NIBBLES; k++) begin
         p = neg_a_ff ? k - 1 : k;
         if (neg_a_ff && k == 0) begin
            nib = SIGN_NIBBLE;
         end else if (p < int'(nd_a_ff)) begin
            nib = ext[EW-4-4*p +: 4];
         end else if (p == int'(nd_a_ff)) begin
            nib = TERM_NIBBLE;
         end else begin
            nib = PAD_NIBBLE;
         end
         item_in.bytes[8*MAX_OUT_BYTES-4-4*k +: 4] = nib;
      end
      // nibbles = sign + digits + terminator, rounded up to whole bytes
      nn  = (NDW+1)'(nd_a_ff) + (NDW+1)'(neg_a_ff) + (NDW+1)'(2);
      tot = nn[NDW:1];
      item_in.total = 3'(tot);
      item_in.emit  = (int'(tot) > MAX_OUT_BYTES) ? 3'(MAX_OUT_BYTES) : 3'(tot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      neg_a_ff <= in_neg;
      dig_a_ff <= in_bcd;
      nd_a_ff  <= nd_a_in;
      item_ff  <= item_in;
   end

   assign out_valid = vb_ff;
   assign out_item  = item_ff;

endmodule

### sv/bpbs_serializer.sv
module bpbs_serializer #(
   parameter int FIFO_DEPTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  bpbs_pkg::enc_item_type in_item,
   output logic                   pop,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_out_byte,
   output logic [2:0]             rsp_total_bytes,
   output logic                   rsp_last
);
   import bpbs_pkg::*;

   localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);

   enc_item_type               mem [FIFO_DEPTH];
   logic [PW-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]              count_ff, count_in;
   logic                       active_ff, active_in;
   logic [8*MAX_OUT_BYTES-1:0] cur_bytes_ff, cur_bytes_in;
   logic [2:0]                 cur_total_ff, cur_total_in;
   logic [2:0]                 left_ff, left_in;
   logic                       load;

   // next value is taken in the cycle the current one shows its last byte
   assign load = (count_ff != '0) && (!active_ff || left_ff == 3'd1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (in_valid) begin
         wr_ptr_in = (int'(wr_ptr_ff) == FIFO_DEPTH - 1) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (load) begin
         rd_ptr_in = (int'(rd_ptr_ff) == FIFO_DEPTH - 1) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in = count_ff + CW'(in_valid) - CW'(load);

      active_in    = active_ff;
      cur_bytes_in = cur_bytes_ff;
      cur_total_in = cur_total_ff;
      left_in      = left_ff;
      if (load) begin
         active_in    = 1'b1;
      end else if (active_ff) begin
         active_in    = (left_ff != 3'd1);
         cur_bytes_in = {cur_bytes_ff[8*MAX_OUT_BYTES-9:0], 8'h00};
         left_in      = left_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         active_ff <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         mem[wr_ptr_ff] <= in_item;
      end
      // a new request loads straight from the queue
      if (load) begin
         cur_bytes_ff <= mem[rd_ptr_ff].bytes;
         cur_total_ff <= mem[rd_ptr_ff].total;
         left_ff      <= mem[rd_ptr_ff].emit;
      end else begin
         cur_bytes_ff <= cur_bytes_in;
         cur_total_ff <= cur_total_in;
         left_ff      <= left_in;
      end
   end

   assign pop             = load;
   assign rsp_valid       = active_ff;
   assign rsp_out_byte    = cur_bytes_ff[8*MAX_OUT_BYTES-1 -: 8];
   assign rsp_total_bytes = cur_total_ff;
   assign rsp_last        = (left_ff == 3'd1);

endmodule

### sv/binary_to_packed_bcd_signed.sv
// Encodes a VALUE_BITS-wide number, unsigned or two's complement, into packed
// BCD bytes: an optional sign nibble 0xB, the decimal digits, a 0xF terminator
// and a 0 pad nibble when needed, at most six bytes. A request is taken when
// start is high and busy is low; requests may come back to back. Each result
// byte appears for exactly one cycle with rsp_valid high and cannot be held
// off. Between the request and its first byte lie one sign stage, one
// shift-and-add-3 stage per 8 bits, two packing stages and the output queue.
// The output sends one byte a cycle while it has any, 1 to 6 per request.
// busy rises when FIFO_DEPTH requests are in flight ahead of the output.
module binary_to_packed_bcd_signed #(
   parameter int VALUE_BITS = bpbs_pkg::VALUE_BITS_DEF,
   parameter int FIFO_DEPTH = bpbs_pkg::FIFO_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  req_is_signed,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_out_byte,
   output logic [2:0]            rsp_total_bytes,
   output logic                  rsp_last
);
   import bpbs_pkg::*;

   localparam int DIGITS = bcd_digits(VALUE_BITS);
   localparam int NS     = (VALUE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int CW     = $clog2(FIFO_DEPTH + 1);

   logic                  accept;
   logic                  pop;
   logic [CW-1:0]         inflight_ff, inflight_in;

   logic                  v0_ff;
   logic                  neg0_ff, neg0_in;
   logic [VALUE_BITS-1:0] mag0_ff, mag0_in;

   logic                  ch_valid [NS+1];
   logic                  ch_neg   [NS+1];
   logic [4*DIGITS-1:0]   ch_bcd   [NS+1];
   logic [VALUE_BITS-1:0] ch_bin   [NS+1];

   logic                  pk_valid;
   enc_item_type          pk_item;

   assign accept = start && !busy;
   assign busy   = (int'(inflight_ff) == FIFO_DEPTH);

   // requests taken but not yet handed to the output stage
   assign inflight_in = inflight_ff + CW'(accept) - CW'(pop);

   // the most negative value wraps to its own true magnitude
   assign neg0_in = req_is_signed && req_value[VALUE_BITS-1];
   assign mag0_in = neg0_in ? (~req_value + VALUE_BITS'(1)) : req_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
         v0_ff       <= 1'b0;
      end else begin
         inflight_ff <= inflight_in;
         v0_ff       <= accept;
      end
   end

   always_ff @(posedge clock) begin
      neg0_ff <= neg0_in;
      mag0_ff <= mag0_in;
   end

   assign ch_valid[0] = v0_ff;
   assign ch_neg[0]   = neg0_ff;
   assign ch_bcd[0]   = '0;
   assign ch_bin[0]   = mag0_ff;

   for (genvar s = 0; s < NS; s++) begin : g_dabble
      localparam int STEPS = (s == NS - 1) ? VALUE_BITS - STEPS_PER_STAGE * (NS - 1)
                                           : STEPS_PER_STAGE;
      bpbs_dabble_stage #(
         .VALUE_BITS (VALUE_BITS),
         .DIGITS     (DIGITS),
         .STEPS      (STEPS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (ch_valid[s]),
         .in_neg    (ch_neg[s]),
         .in_bcd    (ch_bcd[s]),
         .in_bin    (ch_bin[s]),
         .out_valid (ch_valid[s+1]),
         .out_neg   (ch_neg[s+1]),
         .out_bcd   (ch_bcd[s+1]),
         .out_bin   (ch_bin[s+1])
      );
   end

   bpbs_pack #(
      .DIGITS (DIGITS)
   ) u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ch_valid[NS]),
      .in_neg    (ch_neg[NS]),
      .in_bcd    (ch_bcd[NS]),
      .out_valid (pk_valid),
      .out_item  (pk_item)
   );

   bpbs_serializer #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_serializer (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (pk_valid),
      .in_item         (pk_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_total_bytes (rsp_total_bytes),
      .rsp_last        (rsp_last)
   );

endmodule
